// ===== hw/rtl/cre_pkg.sv =====
// Shared types, constants and register map for the reprojection error core.
`default_nettype none
package cre_pkg;
    localparam int unsigned AddrW = 6;
    localparam logic [AddrW-1:0] AddrRotA  = 6'h00;
    localparam logic [AddrW-1:0] AddrRotB  = 6'h08;
    localparam logic [AddrW-1:0] AddrRotC  = 6'h10;
    localparam logic [AddrW-1:0] AddrTrans = 6'h18;
    localparam logic [AddrW-1:0] AddrIntrA = 6'h20;
    localparam logic [AddrW-1:0] AddrIntrB = 6'h28;
    localparam logic [AddrW-1:0] AddrRadial = 6'h30;

    localparam logic signed [63:0] NormLim = 64'sd1048576;
    localparam logic [39:0] AccMax = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [15:0] world_x;
        logic signed [15:0] world_y;
        logic signed [15:0] world_z;
        logic [15:0]        observed_u;
        logic [15:0]        observed_v;
        logic               last_point;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] point_error;
        logic [39:0] error_total;
        logic        behind_camera;
        logic        set_done;
    } t_out_beat;

    typedef struct packed {
        logic [47:0] rot_a;
        logic [47:0] rot_b;
        logic [47:0] rot_c;
        logic [47:0] trans;
        logic [47:0] intr_a;
        logic [47:0] intr_b;
        logic [31:0] radial;
    } t_cfg;

    // Datapath operation selected by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MULA, OP_MULB, OP_MULC, OP_SUMCAM,
        OP_DIVSTART, OP_DIVSTEP, OP_NORM, OP_R2, OP_R4, OP_FAC1, OP_FAC2,
        OP_DIST, OP_PROJ, OP_SQSTEP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        div_y;
        logic [2:0]  sub;
    } t_cmd;

    typedef struct packed {
        logic behind;
        logic div_done;
        logic sq_done;
    } t_sts;

    function automatic logic signed [15:0] fld(input logic [47:0] r, input int unsigned i);
        fld = r[16*i +: 16];
    endfunction

    function automatic logic signed [63:0] clampv(input logic signed [63:0] v);
        if (v > NormLim) clampv = NormLim;
        else if (v < -NormLim) clampv = -NormLim;
        else clampv = v;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/cre_stream_if.sv =====
// Valid/ready stream interface carrying one payload beat.
`default_nettype none
interface cre_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cre_ctrl.sv =====
// Controller state machine sequencing the reprojection datapath.
`default_nettype none
module cre_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire cre_pkg::t_sts  i_sts,
    output cre_pkg::t_cmd       o_cmd
);
    import cre_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MUL  = 10'b0000000010,
        S_SUM  = 10'b0000000100,
        S_DIVS = 10'b0000001000,
        S_DIV  = 10'b0000010000,
        S_NORM = 10'b0000100000,
        S_POLY = 10'b0001000000,
        S_PROJ = 10'b0010000000,
        S_SQ   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_sub, n_sub;
    logic       r_divy, n_divy;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_divy  = r_divy;
        o_cmd   = '{op: OP_NONE, div_y: r_divy, sub: r_sub};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_MUL;
                    n_sub    = 3'd0;
                end
            end
            S_MUL: begin
                priority case (r_sub)
                    3'd0: o_cmd.op = OP_MULA;
                    3'd1: o_cmd.op = OP_MULB;
                    default: o_cmd.op = OP_MULC;
                endcase
                if (r_sub == 3'd2) begin
                    n_state = S_SUM;
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            S_SUM: begin
                o_cmd.op = OP_SUMCAM;
                n_state  = S_DIVS;
                n_divy   = 1'b0;
            end
            S_DIVS: begin
                if (i_sts.behind) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_DIVSTART;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIVSTEP;
                if (i_sts.div_done) begin
                    if (r_divy) begin
                        n_state = S_NORM;
                    end else begin
                        n_divy  = 1'b1;
                        n_state = S_DIVS;
                    end
                end
            end
            S_NORM: begin
                o_cmd.op = OP_NORM;
                n_state  = S_POLY;
                n_sub    = 3'd0;
            end
            S_POLY: begin
                priority case (r_sub)
                    3'd0: o_cmd.op = OP_R2;
                    3'd1: o_cmd.op = OP_R4;
                    3'd2: o_cmd.op = OP_FAC1;
                    3'd3: o_cmd.op = OP_FAC2;
                    default: o_cmd.op = OP_DIST;
                endcase
                if (r_sub == 3'd4) begin
                    n_state = S_PROJ;
                    n_sub   = 3'd0;
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            S_PROJ: begin
                o_cmd.op = OP_PROJ;
                if (r_sub == 3'd3) begin
                    n_state = S_SQ;
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQSTEP;
                if (i_sts.sq_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sub   <= 3'd0;
            r_divy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_divy  <= n_divy;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/cre_datapath.sv =====
// Datapath: camera transform, divider, distortion, projection, square root, sum.
`default_nettype none
module cre_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cre_pkg::t_cfg     i_cfg,
    input  wire cre_pkg::t_in_beat i_in,
    input  wire cre_pkg::t_cmd     i_cmd,
    input  wire logic              i_out_fire,
    output cre_pkg::t_sts          o_sts,
    output cre_pkg::t_out_beat     o_out
);
    import cre_pkg::*;

    // camera values: 16x16 * 3 + t<<14 fits in 36 bits signed
    logic signed [15:0] r_wx, r_wy, r_wz;
    logic [15:0]        r_ou, r_ov;
    logic               r_last;
    logic signed [35:0] r_xc, r_yc, r_zc;
    logic signed [33:0] r_p0, r_p1, r_p2;
    logic               r_behind;
    // restoring divider on magnitudes: dividend |cam|<<16 (52 bits), quotient 52 bits
    logic [51:0]        r_quo;
    logic [35:0]        r_rem;
    logic [35:0]        r_den;
    logic [5:0]         r_dcnt;
    logic               r_qneg;
    logic signed [63:0] r_xq, r_yq;
    logic signed [21:0] r_xn, r_yn;
    logic signed [26:0] r_r2;
    logic signed [42:0] r_r4;
    logic signed [39:0] r_fac;
    logic signed [63:0] r_xd, r_yd;
    logic signed [63:0] r_acc_a;
    logic signed [63:0] r_u, r_v;
    logic [42:0]        r_sq_x;
    logic [42:0]        r_sq_r;
    logic [4:0]         r_sq_cnt;
    logic [15:0]        r_perr;
    logic [39:0]        r_total;
    logic               r_done_q;

    logic signed [63:0] div_q;
    logic [36:0]        trial;
    logic [35:0]        rem_sh;
    logic signed [63:0] du, dv;
    logic signed [21:0] du_n, dv_n;
    logic [42:0]        sq_bit, sq_try;
    logic [40:0]        acc_sum;

    assign o_sts.behind   = r_behind;
    assign o_sts.div_done = (r_dcnt == 6'd0);
    assign o_sts.sq_done  = r_done_q;

    assign rem_sh = {r_rem[34:0], r_quo[51]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_den};
    assign div_q  = r_qneg ? -$signed({12'd0, r_quo}) : $signed({12'd0, r_quo});
    assign du     = clampv($signed({48'd0, r_ou}) - r_u);
    assign dv     = clampv($signed({48'd0, r_ov}) - r_v);
    // clamped differences fit in 22 bits signed
    assign du_n   = 22'(du);
    assign dv_n   = 22'(dv);
    // one result bit per step: bit = 4^cnt
    assign sq_bit = 43'd1 << {r_sq_cnt, 1'b0};
    assign sq_try = r_sq_r + sq_bit;
    assign acc_sum = {1'b0, r_total} + {25'd0, r_perr};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_wx <= i_in.world_x; r_wy <= i_in.world_y; r_wz <= i_in.world_z;
                r_ou <= i_in.observed_u; r_ov <= i_in.observed_v;
                r_last <= i_in.last_point;
            end
            OP_MULA: begin
                r_p0 <= 34'(fld(i_cfg.rot_a, 0) * r_wx);
                r_p1 <= 34'(fld(i_cfg.rot_b, 0) * r_wx);
                r_p2 <= 34'(fld(i_cfg.rot_c, 0) * r_wx);
            end
            OP_MULB: begin
                r_p0 <= r_p0 + 34'(fld(i_cfg.rot_a, 1) * r_wy);
                r_p1 <= r_p1 + 34'(fld(i_cfg.rot_b, 1) * r_wy);
                r_p2 <= r_p2 + 34'(fld(i_cfg.rot_c, 1) * r_wy);
            end
            OP_MULC: begin
                r_p0 <= r_p0 + 34'(fld(i_cfg.rot_a, 2) * r_wz);
                r_p1 <= r_p1 + 34'(fld(i_cfg.rot_b, 2) * r_wz);
                r_p2 <= r_p2 + 34'(fld(i_cfg.rot_c, 2) * r_wz);
            end
            OP_SUMCAM: begin
                r_xc <= 36'(r_p0) + (36'(fld(i_cfg.trans, 0)) <<< 14);
                r_yc <= 36'(r_p1) + (36'(fld(i_cfg.trans, 1)) <<< 14);
                r_zc <= 36'(r_p2) + (36'(fld(i_cfg.trans, 2)) <<< 14);
                r_behind <= (36'(r_p2) + (36'(fld(i_cfg.trans, 2)) <<< 14)) <= 36'sd0;
            end
            OP_DIVSTART: begin
                // hold sign, divide magnitudes, truncate toward zero
                r_quo  <= {(i_cmd.div_y ? (r_yc[35] ? 36'(-r_yc) : r_yc)
                                        : (r_xc[35] ? 36'(-r_xc) : r_xc)), 16'd0};
                r_qneg <= i_cmd.div_y ? r_yc[35] : r_xc[35];
                r_rem  <= '0;
                r_den  <= r_zc;
                r_dcnt <= 6'd52;
            end
            OP_DIVSTEP: begin
                if (r_dcnt != 6'd0) begin
                    r_dcnt <= r_dcnt - 6'd1;
                    if (!trial[36]) begin
                        r_rem <= trial[35:0];
                        r_quo <= {r_quo[50:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[50:0], 1'b0};
                    end
                end else if (i_cmd.div_y) begin
                    r_yq <= div_q;
                end else begin
                    r_xq <= div_q;
                end
            end
            OP_NORM: begin
                r_xn <= 22'(clampv(r_xq));
                r_yn <= 22'(clampv(r_yq));
            end
            OP_R2: r_r2 <= 27'((64'(r_xn) * r_xn + 64'(r_yn) * r_yn) >>> 16);
            OP_R4: r_r4 <= 43'((64'(r_r2) * r_r2) >>> 16);
            OP_FAC1: r_fac <= 40'(64'sd65536
                              + ((64'(fld({16'd0, i_cfg.radial}, 0)) * r_r2) >>> 14));
            OP_FAC2: r_fac <= 40'(64'(r_fac)
                              + ((64'(fld({16'd0, i_cfg.radial}, 1)) * r_r4) >>> 14));
            OP_DIST: begin
                r_xd <= (64'(r_xn) * r_fac) >>> 16;
                r_yd <= (64'(r_yn) * r_fac) >>> 16;
            end
            OP_PROJ: begin
                priority case (i_cmd.sub)
                    3'd0: r_acc_a <= 64'(fld(i_cfg.intr_a, 0)) * r_xd
                                   + (64'(fld(i_cfg.intr_a, 2)) <<< 16);
                    3'd1: r_u <= (r_acc_a + 64'(fld(i_cfg.intr_a, 1)) * r_yd) >>> 16;
                    3'd2: r_acc_a <= 64'(fld(i_cfg.intr_b, 0)) * r_xd
                                   + (64'(fld(i_cfg.intr_b, 2)) <<< 16);
                    default: r_v <= (r_acc_a + 64'(fld(i_cfg.intr_b, 1)) * r_yd) >>> 16;
                endcase
                if (i_cmd.sub == 3'd3) begin
                    r_sq_x   <= '0;
                    r_sq_r   <= '0;
                    r_sq_cnt <= 5'd21;
                    r_done_q <= 1'b0;
                end
            end
            OP_SQSTEP: begin
                if (r_sq_cnt == 5'd21 && r_sq_x == '0) begin
                    r_sq_x <= 43'(du_n * du_n) + 43'(dv_n * dv_n);
                    r_sq_cnt <= 5'd20;
                end else if (!r_done_q) begin
                    if (r_sq_x >= sq_try) begin
                        r_sq_x <= r_sq_x - sq_try;
                        r_sq_r <= (r_sq_r >> 1) + sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    if (r_sq_cnt == 5'd0) r_done_q <= 1'b1;
                    else r_sq_cnt <= r_sq_cnt - 5'd1;
                end
            end
            default: ;
        endcase
    end

    // accumulator and result value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_perr  <= '0;
        end else if (i_cmd.op == OP_DIVSTART && !i_cmd.div_y) begin
            r_perr <= '0;
        end else if (i_cmd.op == OP_SUMCAM) begin
            r_perr <= '0;
        end else if (i_cmd.op == OP_SQSTEP && !r_done_q && r_sq_cnt == 5'd0
                     && !(r_sq_x == '0 && r_sq_cnt == 5'd21)) begin
            // final root bit resolved this cycle
            logic [42:0] root;
            logic [15:0] pe;
            root = (r_sq_x >= sq_try) ? ((r_sq_r >> 1) + sq_bit) : (r_sq_r >> 1);
            pe   = (root > 43'd65535) ? 16'hFFFF : root[15:0];
            r_perr  <= pe;
            r_total <= acc_sum[40] ? AccMax : ((({1'b0, r_total} + {25'd0, pe}) > {1'b0, AccMax})
                       ? AccMax : 40'(r_total + 40'(pe)));
        end else if (i_out_fire && r_last) begin
            r_total <= '0;
        end
    end

    assign o_out.point_error   = r_perr;
    assign o_out.error_total   = r_total;
    assign o_out.behind_camera = r_behind;
    assign o_out.set_done      = r_last;
endmodule
`default_nettype wire

// ===== hw/rtl/camera_reprojection_error_core.sv =====
// Top level of the camera reprojection error core with its APB register file.
// Each point in front of the camera passes two divides (x, then y) and a square root.
// One point is processed at a time; the next is taken once the result beat leaves.
// Points behind the camera skip the divide.
// Reset (synchronous, active low) loads identity rotation, zero other registers,
// clears the running sum and returns the controller to idle.
`default_nettype none
module camera_reprojection_error_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cre_stream_if.sink       s_in,
    cre_stream_if.source     m_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [cre_pkg::AddrW-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import cre_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic in_ready, out_valid;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_a  <= 48'd16384;
            r_cfg.rot_b  <= 48'd1073741824;
            r_cfg.rot_c  <= 48'd70368744177664;
            r_cfg.trans  <= '0;
            r_cfg.intr_a <= '0;
            r_cfg.intr_b <= '0;
            r_cfg.radial <= '0;
        end else if (psel && penable && pwrite) begin
            priority case (paddr)
                AddrRotA:   r_cfg.rot_a  <= pwdata[47:0];
                AddrRotB:   r_cfg.rot_b  <= pwdata[47:0];
                AddrRotC:   r_cfg.rot_c  <= pwdata[47:0];
                AddrTrans:  r_cfg.trans  <= pwdata[47:0];
                AddrIntrA:  r_cfg.intr_a <= pwdata[47:0];
                AddrIntrB:  r_cfg.intr_b <= pwdata[47:0];
                AddrRadial: r_cfg.radial <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority case (paddr)
            AddrRotA:   prdata = {16'd0, r_cfg.rot_a};
            AddrRotB:   prdata = {16'd0, r_cfg.rot_b};
            AddrRotC:   prdata = {16'd0, r_cfg.rot_c};
            AddrTrans:  prdata = {16'd0, r_cfg.trans};
            AddrIntrA:  prdata = {16'd0, r_cfg.intr_a};
            AddrIntrB:  prdata = {16'd0, r_cfg.intr_b};
            AddrRadial: prdata = {32'd0, r_cfg.radial};
            default:    prdata = '0;
        endcase
    end

    cre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (m_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cre_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in       (s_in.data),
        .i_cmd      (cmd),
        .i_out_fire (out_valid && m_out.ready),
        .o_sts      (sts),
        .o_out      (m_out.data)
    );

    assign s_in.ready  = in_ready;
    assign m_out.valid = out_valid;
endmodule
`default_nettype wire

// ===== tb/camera_reprojection_error_core_test.sv =====
// Self-checking testbench for the camera reprojection error core.
`timescale 1ns / 1ps
`default_nettype none
module camera_reprojection_error_core_test;
    import cre_pkg::*;

    localparam int unsigned StallLimit = 20000;
    localparam int unsigned DrainCycles = 200;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AddrW-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    cre_stream_if #(.T(t_in_beat)) pt_if ();
    cre_stream_if #(.T(t_out_beat)) err_if ();

    camera_reprojection_error_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (pt_if.sink),
        .m_out   (err_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the register file and the running sum.
    t_cfg        cam_cfg;
    logic [39:0] sum_shadow;
    t_out_beat   pending_errors[$];

    int unsigned fail_count;
    int unsigned points_sent;
    int unsigned errors_seen;
    int unsigned behind_seen;
    int unsigned sets_closed;
    int unsigned idle_cycles = 0;
    bit          no_idle;
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] coeff(input logic [47:0] r, input int unsigned i);
        logic signed [15:0] f;
        f = r[16*i +: 16];
        return 64'(f);
    endfunction

    function automatic logic signed [63:0] limit_mag(input logic signed [63:0] v);
        if (v > 64'sd1048576) return 64'sd1048576;
        if (v < -64'sd1048576) return -64'sd1048576;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem = x;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Compute the expected result beat and advance the running sum.
    function automatic t_out_beat predict_error(input t_in_beat b);
        logic signed [63:0] wx, wy, wz, xc, yc, zc, xn, yn, r2, r4, fac;
        logic signed [63:0] xd, yd, pu, pv, du, dv, ou, ov;
        logic [63:0] perr;
        logic [40:0] sum;
        t_out_beat r;
        wx = 64'(b.world_x);
        wy = 64'(b.world_y);
        wz = 64'(b.world_z);
        ou = $signed({48'd0, b.observed_u});
        ov = $signed({48'd0, b.observed_v});
        xc = coeff(cam_cfg.rot_a, 0) * wx + coeff(cam_cfg.rot_a, 1) * wy
            + coeff(cam_cfg.rot_a, 2) * wz + coeff(cam_cfg.trans, 0) * 64'sd16384;
        yc = coeff(cam_cfg.rot_b, 0) * wx + coeff(cam_cfg.rot_b, 1) * wy
            + coeff(cam_cfg.rot_b, 2) * wz + coeff(cam_cfg.trans, 1) * 64'sd16384;
        zc = coeff(cam_cfg.rot_c, 0) * wx + coeff(cam_cfg.rot_c, 1) * wy
            + coeff(cam_cfg.rot_c, 2) * wz + coeff(cam_cfg.trans, 2) * 64'sd16384;
        perr = 0;
        r.behind_camera = (zc <= 0);
        if (!r.behind_camera) begin
            xn = limit_mag((xc * 64'sd65536) / zc);
            yn = limit_mag((yc * 64'sd65536) / zc);
            r2 = (xn * xn + yn * yn) >>> 16;
            r4 = (r2 * r2) >>> 16;
            fac = 64'sd65536 + ((coeff({16'd0, cam_cfg.radial}, 0) * r2) >>> 14)
                + ((coeff({16'd0, cam_cfg.radial}, 1) * r4) >>> 14);
            xd = (xn * fac) >>> 16;
            yd = (yn * fac) >>> 16;
            pu = (coeff(cam_cfg.intr_a, 0) * xd + coeff(cam_cfg.intr_a, 1) * yd
                + coeff(cam_cfg.intr_a, 2) * 64'sd65536) >>> 16;
            pv = (coeff(cam_cfg.intr_b, 0) * xd + coeff(cam_cfg.intr_b, 1) * yd
                + coeff(cam_cfg.intr_b, 2) * 64'sd65536) >>> 16;
            du = limit_mag(ou - pu);
            dv = limit_mag(ov - pv);
            perr = int_sqrt(64'(du * du) + 64'(dv * dv));
            if (perr > 64'hFFFF) perr = 64'hFFFF;
            sum = {1'b0, sum_shadow} + 41'(perr);
            sum_shadow = (sum > 41'(AccMax)) ? AccMax : sum[39:0];
        end
        r.point_error = perr[15:0];
        r.error_total = sum_shadow;
        r.set_done = b.last_point;
        if (b.last_point) sum_shadow = '0;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        if (no_idle || $urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_point(input t_in_beat b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.data <= b;
        do @(posedge i_clk); while (!pt_if.ready);
        pending_errors.insert(pending_errors.size(), predict_error(b));
        points_sent++;
    endtask

    task automatic write_reg(input logic [AddrW-1:0] addr, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            AddrRotA:   cam_cfg.rot_a = val[47:0];
            AddrRotB:   cam_cfg.rot_b = val[47:0];
            AddrRotC:   cam_cfg.rot_c = val[47:0];
            AddrTrans:  cam_cfg.trans = val[47:0];
            AddrIntrA:  cam_cfg.intr_a = val[47:0];
            AddrIntrB:  cam_cfg.intr_b = val[47:0];
            AddrRadial: cam_cfg.radial = val[31:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stop offering, drain every expected beat, then let the core settle.
    task automatic wait_idle();
        pt_if.valid <= 1'b0;
        while (pending_errors.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic [47:0] pack3(input int a, input int b, input int c);
        logic [15:0] fa, fb, fc;
        fa = a[15:0];
        fb = b[15:0];
        fc = c[15:0];
        return {fc, fb, fa};
    endfunction

    function automatic int srand(input int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    // Plausible camera: near-identity rotation, positive depth offset, real intrinsics.
    task automatic load_plausible_camera();
        wait_idle();
        write_reg(AddrRotA, {16'd0, pack3(16384 + srand(800), srand(1500), srand(1500))});
        write_reg(AddrRotB, {16'd0, pack3(srand(1500), 16384 + srand(800), srand(1500))});
        write_reg(AddrRotC, {16'd0, pack3(srand(1500), srand(1500), 16384 + srand(800))});
        write_reg(AddrTrans, {16'd0, pack3(srand(800), srand(800),
            int'($urandom_range(400, 16000)))});
        write_reg(AddrIntrA, {16'd0, pack3(int'($urandom_range(4000, 16000)), srand(40),
            int'($urandom_range(3000, 10000)))});
        write_reg(AddrIntrB, {16'd0, pack3(srand(40), int'($urandom_range(4000, 16000)),
            int'($urandom_range(3000, 8000)))});
        write_reg(AddrRadial, {32'd0, 16'(srand(2000)), 16'(srand(4000))});
    endtask

    task automatic load_raw_camera();
        wait_idle();
        write_reg(AddrRotA, {$urandom, $urandom});
        write_reg(AddrRotB, {$urandom, $urandom});
        write_reg(AddrRotC, {$urandom, $urandom});
        write_reg(AddrTrans, {$urandom, $urandom});
        write_reg(AddrIntrA, {$urandom, $urandom});
        write_reg(AddrIntrB, {$urandom, $urandom});
        write_reg(AddrRadial, {32'd0, $urandom});
    endtask

    function automatic t_in_beat scene_point(input int unsigned last_odds);
        t_in_beat b;
        if ($urandom_range(0, 5) == 0) begin
            b.world_x = 16'($urandom);
            b.world_y = 16'($urandom);
            b.world_z = 16'($urandom);
        end else begin
            b.world_x = 16'(srand(3000));
            b.world_y = 16'(srand(3000));
            b.world_z = 16'(srand(2000));
        end
        b.observed_u = 16'($urandom);
        b.observed_v = 16'($urandom);
        b.last_point = ($urandom_range(0, last_odds) == 0);
        return b;
    endfunction

    task automatic test_reset_defaults();
        t_in_beat b;
        // Identity camera with zero intrinsics: projection lands on the origin.
        b = '{world_x: 16'sd160, world_y: -16'sd80, world_z: 16'sd32, observed_u: 16'd300,
            observed_v: 16'd400, last_point: 1'b0};
        send_point(b);
        b.world_z = 16'sd0;
        send_point(b);
        b.world_z = -16'sd5;
        b.last_point = 1'b1;
        send_point(b);
    endtask

    task automatic test_directed_extremes();
        t_in_beat b;
        int signed ext[4];
        ext = '{-32768, 32767, 0, 1};
        wait_idle();
        write_reg(AddrRotA, {16'd0, pack3(16384, 0, 0)});
        write_reg(AddrRotB, {16'd0, pack3(0, 16384, 0)});
        write_reg(AddrRotC, {16'd0, pack3(0, 0, 16384)});
        write_reg(AddrTrans, {16'd0, pack3(0, 0, 1600)});
        write_reg(AddrIntrA, {16'd0, pack3(8000, 0, 5120)});
        write_reg(AddrIntrB, {16'd0, pack3(0, 8000, 3840)});
        write_reg(AddrRadial, {32'd0, 16'sh1000, 16'shE000});
        for (int i = 0; i < 4; i++) begin
            b.world_x = 16'(ext[i]);
            b.world_y = 16'(ext[3 - i]);
            b.world_z = 16'(ext[(i + 1) % 4]);
            b.observed_u = (i % 2) ? 16'hFFFF : 16'h0000;
            b.observed_v = (i % 2) ? 16'h0000 : 16'hFFFF;
            b.last_point = (i == 3);
            send_point(b);
        end
        // Depth exactly zero, then far behind, inside one set.
        b = '{world_x: 16'sd100, world_y: 16'sd100, world_z: -16'sd1600, observed_u: 16'd50,
            observed_v: 16'd60, last_point: 1'b0};
        send_point(b);
        b.world_z = -16'sd32768;
        send_point(b);
        // Huge normalized coordinates hit the clamp; observed far away saturates the error.
        b = '{world_x: 16'sd32767, world_y: -16'sd32768, world_z: -16'sd1599,
            observed_u: 16'hFFFF, observed_v: 16'hFFFF, last_point: 1'b0};
        send_point(b);
        // A point behind the camera that also closes the set.
        b = '{world_x: 16'sd0, world_y: 16'sd0, world_z: -16'sd2000, observed_u: 16'd0,
            observed_v: 16'd0, last_point: 1'b1};
        send_point(b);
        // Extreme register values.
        wait_idle();
        write_reg(AddrRotA, {16'd0, pack3(32767, -32768, 32767)});
        write_reg(AddrRotC, {16'd0, pack3(-32768, 32767, 32767)});
        write_reg(AddrTrans, {16'd0, pack3(32767, -32768, 32767)});
        write_reg(AddrIntrA, {16'd0, pack3(32767, -32768, -32768)});
        write_reg(AddrIntrB, {16'd0, pack3(-32768, 32767, 32767)});
        write_reg(AddrRadial, {32'd0, 16'sh7FFF, 16'sh8000});
        for (int i = 0; i < 6; i++) send_point(scene_point(3));
        wait_idle();
        write_reg(AddrRadial, {32'd0, 16'sh8000, 16'sh7FFF});
        write_reg(AddrRotB, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++) send_point(scene_point(3));
    endtask

    task automatic test_random_scenes(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                if ($urandom_range(0, 3) == 0) load_raw_camera();
                else load_plausible_camera();
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_point(scene_point(7));
        end
    endtask

    task automatic test_output_backpressure();
        load_plausible_camera();
        no_idle = 1'b1;
        hold_requests++;
        for (int i = 0; i < 12; i++) send_point(scene_point(5));
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            err_if.ready <= 1'b0;
            hold_served <= 0;
            hold_left <= 0;
            stall_left <= 0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= 600;
            err_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            err_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            err_if.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                : $urandom_range(0, 2);
            err_if.ready <= 1'b0;
        end else begin
            err_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat got;
        if (i_rst_n && err_if.valid && err_if.ready) begin
            got = err_if.data;
            errors_seen++;
            if (got.behind_camera) behind_seen++;
            if (got.set_done) sets_closed++;
            if (pending_errors.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_errors.pop_front();
                if (got.point_error !== want.point_error) begin
                    $display("%0t: point_error expected %h actual %h", $time,
                        want.point_error, got.point_error);
                    fail_count++;
                end
                if (got.error_total !== want.error_total) begin
                    $display("%0t: error_total expected %h actual %h", $time,
                        want.error_total, got.error_total);
                    fail_count++;
                end
                if (got.behind_camera !== want.behind_camera) begin
                    $display("%0t: behind_camera expected %b actual %b", $time,
                        want.behind_camera, got.behind_camera);
                    fail_count++;
                end
                if (got.set_done !== want.set_done) begin
                    $display("%0t: set_done expected %b actual %b", $time,
                        want.set_done, got.set_done);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (err_if.valid && err_if.ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pt_if.valid = 1'b0;
        pt_if.data = '0;
        cam_cfg = '{rot_a: 48'd16384, rot_b: 48'd1073741824, rot_c: 48'd70368744177664,
            trans: '0, intr_a: '0, intr_b: '0, radial: '0};
        sum_shadow = '0;
        fail_count = 0;
        points_sent = 0;
        errors_seen = 0;
        behind_seen = 0;
        sets_closed = 0;
        no_idle = 1'b0;
        hold_requests = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_extremes();
        test_output_backpressure();
        test_random_scenes(1600);
        test_output_backpressure();
        wait_idle();

        $display("Covered %0d points in %0d results: %0d behind the camera, %0d sets closed.",
            points_sent, errors_seen, behind_seen, sets_closed);
        $display("Camera settings swept from identity and plausible rigs to raw extremes.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/cre_pkg.sv
hw/rtl/cre_stream_if.sv
hw/rtl/cre_ctrl.sv
hw/rtl/cre_datapath.sv
hw/rtl/camera_reprojection_error_core.sv
tb/camera_reprojection_error_core_test.sv
